// ----- rtl/core/wisd_pkg.sv -----
// Package for the windowed input sequence detector: types, codes and reset constants.
package wisd_pkg;

    localparam int CODE_W        = 6;
    localparam int LENGTH_W      = 4;
    localparam int LIMIT_W       = 6;
    localparam int PATTERN_W     = 48;
    localparam int MAX_STEPS     = 8;
    localparam int STEP_W        = 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int DEF_HISTORY_DEPTH = 32;

    localparam logic [LENGTH_W-1:0]  CMD0_LENGTH_RST  = 4'd4;
    localparam logic [LIMIT_W-1:0]   CMD0_LIMIT_RST   = 6'd30;
    localparam logic [PATTERN_W-1:0] CMD0_PATTERN_RST = 48'd8455428;
    localparam logic [LENGTH_W-1:0]  CMD1_LENGTH_RST  = 4'd4;
    localparam logic [LIMIT_W-1:0]   CMD1_LIMIT_RST   = 6'd30;
    localparam logic [PATTERN_W-1:0] CMD1_PATTERN_RST = 48'd8470800;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CMD0_LENGTH  = 3'd0,
        CFG_CMD0_LIMIT   = 3'd1,
        CFG_CMD0_PATTERN = 3'd2,
        CFG_CMD1_LENGTH  = 3'd3,
        CFG_CMD1_LIMIT   = 3'd4,
        CFG_CMD1_PATTERN = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/core/windowed_input_sequence_detector_core.sv -----
// Windowed input sequence detector: frame history memory, command scanner and result stage.
//
// Each input beat is one frame of stick and button state. The frame is packed into a
// 6-bit code and written into a history memory of HISTORY_DEPTH entries; then command
// zero and command one are checked in turn by a backward scan of that memory, one read
// per cycle through its single registered port. A scan has a setup step and then compare
// steps; it ends once the last step of the pattern matches or once the scan has gone back
// as far as the limit. On a match the whole history reads as zero from then on: the
// per-entry valid bits are all cleared together, so there is no clearing pass after
// reset. Results (up to two per frame, command zero first, tlast on the final one) sit
// in an output register, and the next frame is taken while they drain; a frame's
// results are loaded only once the previous ones are gone.
module windowed_input_sequence_detector_core #(
    parameter int HISTORY_DEPTH = wisd_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [0] stick_up, [1] stick_down, [2] stick_left, [3] stick_right, [4] fire_button
    input  logic [7:0]                           s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] matched_command
    output logic [7:0]                           m_tdata,
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [wisd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wisd_pkg::PATTERN_W-1:0]       cfg_data
);
    import wisd_pkg::*;

    localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int PW = AW + 1;
    localparam int BW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW = (BW > LIMIT_W) ? BW : LIMIT_W;

    // Configuration registers.
    logic [LENGTH_W-1:0]  cmd0_length_reg, cmd1_length_reg;
    logic [LIMIT_W-1:0]   cmd0_limit_reg, cmd1_limit_reg;
    logic [PATTERN_W-1:0] cmd0_pattern_reg, cmd1_pattern_reg;

    // Control state.
    state_t          state_reg, state_next;
    logic            cmd_reg, cmd_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CW-1:0]   back_reg, back_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [1:0]      hit_reg, hit_next;
    logic [1:0]      pend_reg, pend_next;
    logic [HISTORY_DEPTH-1:0] valid_reg;

    // History memory and its read port.
    logic [CODE_W-1:0] hist_mem [HISTORY_DEPTH];
    logic [CODE_W-1:0] rd_data_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     rd_addr;
    logic [PW-1:0]     rd_sum;

    logic              in_beat;
    logic              clear_hist;
    logic [CODE_W-1:0] frame_code;
    logic [CODE_W-1:0] hist_code;
    logic [CODE_W-1:0] want_code;
    logic [LENGTH_W-1:0]  len_sel;
    logic [STEP_W-1:0]    len_eff;
    logic [CW-1:0]        lim_sel;
    logic [CW-1:0]        lim_eff;
    logic [PATTERN_W-1:0] pat_sel;
    logic [2:0]           step_idx;
    logic [CW-1:0]        back_inc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign frame_code = {s_tdata[4:0], 1'b0};

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd0_length_reg  <= CMD0_LENGTH_RST;
            cmd0_limit_reg   <= CMD0_LIMIT_RST;
            cmd0_pattern_reg <= CMD0_PATTERN_RST;
            cmd1_length_reg  <= CMD1_LENGTH_RST;
            cmd1_limit_reg   <= CMD1_LIMIT_RST;
            cmd1_pattern_reg <= CMD1_PATTERN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CMD0_LENGTH:  cmd0_length_reg  <= cfg_data[LENGTH_W-1:0];
                CFG_CMD0_LIMIT:   cmd0_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_CMD0_PATTERN: cmd0_pattern_reg <= cfg_data;
                CFG_CMD1_LENGTH:  cmd1_length_reg  <= cfg_data[LENGTH_W-1:0];
                CFG_CMD1_LIMIT:   cmd1_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_CMD1_PATTERN: cmd1_pattern_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Settings of the command under scan, with length and limit clamped.
    always_comb
    begin
        len_sel = cmd_reg ? cmd1_length_reg : cmd0_length_reg;
        lim_sel = CW'(cmd_reg ? cmd1_limit_reg : cmd0_limit_reg);
        pat_sel = cmd_reg ? cmd1_pattern_reg : cmd0_pattern_reg;
        len_eff = (STEP_W'(len_sel) > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                          : STEP_W'(len_sel);
        lim_eff = (lim_sel > CW'(HISTORY_DEPTH)) ? CW'(HISTORY_DEPTH) : lim_sel;
        step_idx  = 3'(step_reg - STEP_W'(1));
        want_code = pat_sel[CODE_W*step_idx +: CODE_W];
        // A cleared entry reads as zero.
        hist_code = rd_valid_reg ? rd_data_reg : '0;
        back_inc  = back_reg + CW'(1);
    end

    // Scan sequencer.
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        back_next  = back_reg;
        wp_next    = wp_reg;
        hit_next   = hit_reg;
        pend_next  = pend_reg;
        clear_hist = 1'b0;

        // Result register drains one beat at a time, command zero first.
        if (m_tvalid && m_tready)
        begin
            if (pend_reg[0])
                pend_next[0] = 1'b0;
            else
                pend_next[1] = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    cmd_next   = 1'b0;
                    hit_next   = 2'b00;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                back_next = '0;
                step_next = len_eff;
                if (len_sel == '0 || lim_eff == '0)
                begin
                    if (cmd_reg)
                        state_next = ST_DONE;
                    else
                        cmd_next = 1'b1;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hist_code == want_code)
                begin
                    // The same entry may also satisfy the next earlier step.
                    if (step_reg == STEP_W'(1))
                    begin
                        hit_next[cmd_reg] = 1'b1;
                        clear_hist = 1'b1;
                        state_next = cmd_reg ? ST_DONE : ST_LOAD;
                        cmd_next   = 1'b1;
                    end
                    else
                    begin
                        step_next = step_reg - STEP_W'(1);
                    end
                end
                else
                begin
                    back_next = back_inc;
                    if (back_inc >= lim_eff)
                    begin
                        state_next = cmd_reg ? ST_DONE : ST_LOAD;
                        cmd_next   = 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (pend_next == 2'b00)
                begin
                    pend_next  = hit_reg;
                    wp_next    = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Read address: newest entry minus back, wrapped around the history.
    always_comb
    begin
        rd_sum  = PW'(wp_reg) + PW'(HISTORY_DEPTH) - PW'(back_next);
        rd_addr = (rd_sum >= PW'(HISTORY_DEPTH)) ? AW'(rd_sum - PW'(HISTORY_DEPTH))
                                                 : AW'(rd_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cmd_reg   <= 1'b0;
            step_reg  <= '0;
            back_reg  <= '0;
            wp_reg    <= '0;
            hit_reg   <= 2'b00;
            pend_reg  <= 2'b00;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            step_reg  <= step_next;
            back_reg  <= back_next;
            wp_reg    <= wp_next;
            hit_reg   <= hit_next;
            pend_reg  <= pend_next;
            if (clear_hist)
                valid_reg <= '0;
            else if (in_beat)
                valid_reg[wp_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
            hist_mem[wp_reg] <= frame_code;
        rd_data_reg  <= hist_mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr];
    end

    assign m_tvalid = pend_reg[0] || pend_reg[1];
    assign m_tdata  = {7'b0, !pend_reg[0]};
    assign m_tlast  = pend_reg[0] ? !pend_reg[1] : 1'b1;

endmodule
